/* rtl/kpc_pkg.sv */
// Shared types, constants and helpers for the key press classifier.
// No dependencies; every other file of the block imports this package.
package kpc_pkg;

  // Dwell counter and threshold widths
  localparam int unsigned CountWidth = 16;
  localparam int unsigned CfgWidth   = 16;
  localparam int unsigned CmpWidth   =
    ((CountWidth > CfgWidth) ? CountWidth : CfgWidth) + 1;
  localparam int unsigned ClassWidth = 3;

  // Configuration port
  localparam int unsigned AddrWidth = 3;
  localparam int unsigned DataWidth = 32;

  localparam logic [CfgWidth-1:0] ShortTimeRst = 16'd5;
  localparam logic [CfgWidth-1:0] LongTimeRst  = 16'd50;

  // Register index, taken from paddr[2]
  typedef enum logic [0:0] {
    REG_SHORT_TIME = 1'b0,
    REG_LONG_TIME  = 1'b1
  } kpc_reg_e;

  // Key class held as one-hot state
  typedef enum logic [4:0] {
    CLS_IDLE    = 5'b00001,
    CLS_PRESS   = 5'b00010,
    CLS_SHORT   = 5'b00100,
    CLS_LONG    = 5'b01000,
    CLS_RELEASE = 5'b10000
  } kpc_class_e;

  // Class codes as seen on the result channel
  localparam logic [ClassWidth-1:0] CodeIdle    = 3'd0;
  localparam logic [ClassWidth-1:0] CodePress   = 3'd1;
  localparam logic [ClassWidth-1:0] CodeShort   = 3'd2;
  localparam logic [ClassWidth-1:0] CodeLong    = 3'd3;
  localparam logic [ClassWidth-1:0] CodeRelease = 3'd4;

  typedef struct packed {
    logic [CfgWidth-1:0] short_time;
    logic [CfgWidth-1:0] long_time;
  } kpc_cfg_t;

  typedef struct packed {
    logic [ClassWidth-1:0] key_class;
    logic                  hold_level;
    logic                  toggle_level;
    logic                  shot_pulse;
  } kpc_result_t;

  // Map the one-hot class onto its result code
  function automatic logic [ClassWidth-1:0] class_code(input kpc_class_e cls);
    logic [ClassWidth-1:0] code;
    unique case (cls)
      CLS_IDLE:    code = CodeIdle;
      CLS_PRESS:   code = CodePress;
      CLS_SHORT:   code = CodeShort;
      CLS_LONG:    code = CodeLong;
      CLS_RELEASE: code = CodeRelease;
      default:     code = CodeIdle;
    endcase
    return code;
  endfunction

endpackage

/* rtl/kpc_cfg_regs.sv */
// APB-style configuration registers: short and long dwell thresholds.
// Depends on kpc_pkg.
module kpc_cfg_regs (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [kpc_pkg::AddrWidth-1:0] paddr,
  input  logic [kpc_pkg::DataWidth-1:0] pwdata,
  output logic [kpc_pkg::DataWidth-1:0] prdata,
  output logic                     pready,
  output kpc_pkg::kpc_cfg_t        cfg_o
);
  import kpc_pkg::*;

  kpc_reg_e            reg_idx;
  logic                wr_en;
  logic [CfgWidth-1:0] short_time_d, short_time_q;
  logic [CfgWidth-1:0] long_time_d, long_time_q;

  // Decode the access
  assign reg_idx = kpc_reg_e'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Pick the written register
  always_comb begin
    short_time_d = short_time_q;
    long_time_d  = long_time_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_SHORT_TIME: short_time_d = pwdata[CfgWidth-1:0];
        REG_LONG_TIME:  long_time_d  = pwdata[CfgWidth-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_time_q <= ShortTimeRst;
      long_time_q  <= LongTimeRst;
    end else begin
      short_time_q <= short_time_d;
      long_time_q  <= long_time_d;
    end
  end

  // Return the addressed register
  always_comb begin
    unique case (reg_idx)
      REG_SHORT_TIME: prdata = DataWidth'(short_time_q);
      REG_LONG_TIME:  prdata = DataWidth'(long_time_q);
      default:        prdata = '0;
    endcase
  end

  assign cfg_o.short_time = short_time_q;
  assign cfg_o.long_time  = long_time_q;

endmodule

/* rtl/kpc_step.sv */
// Classifier state and its per-sample update: dwell counter, class and
// the hold, toggle and single-shot flags. Depends on kpc_pkg.
module kpc_step (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic                 level_i,
  input  kpc_pkg::kpc_cfg_t    cfg_i,
  output kpc_pkg::kpc_result_t result_o
);
  import kpc_pkg::*;

  logic [CountWidth-1:0] cnt_q, cnt_d, cnt_base, cnt_inc;
  logic [CmpWidth-1:0]   cnt_w, st_w, st1_w, lt_w;
  logic                  hit_long, hit_short1, hit_short;
  logic                  last_q;
  kpc_class_e            class_q, class_d;
  logic                  hold_q, hold_d;
  logic                  toggle_q, toggle_d;
  logic                  tarm_q, tarm_d;
  logic                  sarm_q, sarm_d;
  logic                  shot;

  // Clear on a level change, then count up with saturation
  always_comb begin
    cnt_base   = (level_i != last_q) ? '0 : cnt_q;
    cnt_inc    = (&cnt_base) ? cnt_base : cnt_base + CountWidth'(1);
    cnt_w      = CmpWidth'(cnt_inc);
    st_w       = CmpWidth'(cfg_i.short_time);
    st1_w      = st_w + CmpWidth'(1);
    lt_w       = CmpWidth'(cfg_i.long_time);
    hit_long   = cnt_w >= lt_w;
    hit_short1 = cnt_w >= st1_w;
    hit_short  = cnt_w >= st_w;
  end

  // Advance the class; a settled class holds the counter at zero
  always_comb begin
    cnt_d   = cnt_inc;
    class_d = class_q;
    if (!level_i) begin
      if (class_q != CLS_IDLE) begin
        priority if (hit_short1) class_d = CLS_IDLE;
        else if (hit_short)      class_d = CLS_RELEASE;
        else                     class_d = class_q;
      end else begin
        cnt_d = '0;
      end
    end else begin
      if (class_q != CLS_LONG) begin
        priority if (hit_long)   class_d = CLS_LONG;
        else if (hit_short1)     class_d = CLS_SHORT;
        else if (hit_short)      class_d = CLS_PRESS;
        else                     class_d = class_q;
      end else begin
        cnt_d = '0;
      end
    end
  end

  // Derive hold, toggle and single shot from the new class
  always_comb begin
    hold_d   = hold_q;
    toggle_d = toggle_q;
    tarm_d   = tarm_q;
    sarm_d   = sarm_q;
    shot     = 1'b0;
    unique case (class_d)
      CLS_SHORT: begin
        hold_d = 1'b1;
        if (tarm_q) begin
          toggle_d = ~toggle_q;
          tarm_d   = 1'b0;
        end
        if (sarm_q) begin
          shot   = 1'b1;
          sarm_d = 1'b0;
        end
      end
      CLS_RELEASE: begin
        hold_d = 1'b0;
        tarm_d = 1'b1;
      end
      CLS_PRESS: sarm_d = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      last_q   <= 1'b0;
      class_q  <= CLS_IDLE;
      hold_q   <= 1'b0;
      toggle_q <= 1'b0;
      tarm_q   <= 1'b1;
      sarm_q   <= 1'b1;
    end else if (step_i) begin
      cnt_q    <= cnt_d;
      last_q   <= level_i;
      class_q  <= class_d;
      hold_q   <= hold_d;
      toggle_q <= toggle_d;
      tarm_q   <= tarm_d;
      sarm_q   <= sarm_d;
    end
  end

  assign result_o.key_class    = class_code(class_d);
  assign result_o.hold_level   = hold_d;
  assign result_o.toggle_level = toggle_d;
  assign result_o.shot_pulse   = shot;

endmodule

/* rtl/key_press_classifier.sv */
// Top level of the key press classifier: input register, classifier step
// and result register. Depends on kpc_pkg, kpc_cfg_regs and kpc_step.
//
// Usage:
//   One request on the input channel carries one sampled key level. Each
//   request yields exactly one result: the key class (0 idle, 1 press,
//   2 short press, 3 held long, 4 release), the hold level, the toggle
//   level and a single-shot pulse.
//   From input acceptance to result valid, the sample is captured in the
//   input register, classified in one pass and captured in the result
//   register. Throughput is one request per cycle while the receiver does not
//   stall; the classifier state update is combinational, which sets that rate.
//   When the receiver stalls, the result register holds its value and one
//   more request is taken into the input register; in_ready_o then drops
//   until the result is taken. Thresholds are written over the APB-style
//   port at byte addresses 0 (short time) and 4 (long time); the user must
//   do so only while the block is idle, which the block does not enforce.
//   Reset clears both stages, returns the class to idle with the counter at
//   zero, arms toggle and single shot and restores thresholds 5 and 50.
module key_press_classifier (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [kpc_pkg::AddrWidth-1:0]  paddr,
  input  logic [kpc_pkg::DataWidth-1:0]  pwdata,
  output logic [kpc_pkg::DataWidth-1:0]  prdata,
  output logic                           pready,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           key_level_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [kpc_pkg::ClassWidth-1:0] key_class_o,
  output logic                           hold_level_o,
  output logic                           toggle_level_o,
  output logic                           shot_pulse_o
);
  import kpc_pkg::*;

  kpc_cfg_t    cfg;
  kpc_result_t result;
  kpc_result_t out_d, out_q;
  logic        in_valid_d, in_valid_q;
  logic        level_d, level_q;
  logic        out_valid_d, out_valid_q;
  logic        advance;
  logic        step;

  kpc_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Move a request on whenever the result register is free or being taken
  assign advance    = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  kpc_step u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .level_i  (level_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  // Input and result stage next values
  always_comb begin
    in_valid_d  = in_ready_o ? in_valid_i : in_valid_q;
    level_d     = (in_valid_i && in_ready_o) ? key_level_i : level_q;
    out_valid_d = advance ? in_valid_q : out_valid_q;
    out_d       = step ? result : out_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    level_q <= level_d;
    out_q   <= out_d;
  end

  assign out_valid_o    = out_valid_q;
  assign key_class_o    = out_q.key_class;
  assign hold_level_o   = out_q.hold_level;
  assign toggle_level_o = out_q.toggle_level;
  assign shot_pulse_o   = out_q.shot_pulse;

endmodule

/* rtl/kpc_checker.sv */
// Port-level checks for the key press classifier, bound to the top level.
// Depends on kpc_pkg and key_press_classifier.
module kpc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [kpc_pkg::ClassWidth-1:0] key_class_o,
  input logic                           hold_level_o,
  input logic                           toggle_level_o,
  input logic                           shot_pulse_o
);
  import kpc_pkg::*;

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(key_class_o) && $stable(hold_level_o) &&
      $stable(toggle_level_o) && $stable(shot_pulse_o))
    else $error("stalled result changed");

  // An accepted request yields out_valid_o via input and result registers
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> ##1 out_valid_o)
    else $error("result missing after accepted request");

  // The single shot fires only on a short press, with hold set
  a_shot_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && shot_pulse_o |-> key_class_o == CodeShort && hold_level_o)
    else $error("shot pulse outside short press");

  // Short press sets hold, release clears it
  a_hold_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (key_class_o != CodeShort || hold_level_o) &&
      (key_class_o != CodeRelease || !hold_level_o))
    else $error("hold level disagrees with class");

endmodule

bind key_press_classifier kpc_checker u_kpc_checker (.*);

/* dv/key_press_classifier_tb.sv */
// Self-checking testbench for key_press_classifier: a scoreboard class
// predicts every result from accepted key samples and the thresholds written.
// Depends on kpc_pkg and the RTL of key_press_classifier.
module key_press_classifier_tb;
  import kpc_pkg::*;

  localparam int StallLimit = 4000;

  // Tracks the classifier state and the results still owed by the block
  class press_tracker;
    logic [CfgWidth-1:0]   short_time;
    logic [CfgWidth-1:0]   long_time;
    logic                  last_level;
    longint unsigned       dwell;
    logic [ClassWidth-1:0] cls;
    logic                  hold_flag;
    logic                  tog_flag;
    logic                  tog_armed;
    logic                  shot_armed;
    kpc_result_t           due_q[$];
    int                    fail_count;

    function new();
      short_time = ShortTimeRst;
      long_time  = LongTimeRst;
      last_level = 1'b0;
      dwell      = 0;
      cls        = CodeIdle;
      hold_flag  = 1'b0;
      tog_flag   = 1'b0;
      tog_armed  = 1'b1;
      shot_armed = 1'b1;
      fail_count = 0;
    endfunction

    function void set_threshold(kpc_reg_e idx, logic [DataWidth-1:0] value);
      if (idx == REG_SHORT_TIME) short_time = value[CfgWidth-1:0];
      else long_time = value[CfgWidth-1:0];
    endfunction

    // Advance the dwell counter, saturating at its maximum
    function void bump_dwell();
      if (dwell < ((64'd1 << CountWidth) - 1)) dwell++;
    endfunction

    // Classify one accepted key sample and queue the result it owes
    function void take_sample(logic lvl);
      longint unsigned st;
      longint unsigned lt;
      kpc_result_t     res;
      st = short_time;
      lt = long_time;
      res.shot_pulse = 1'b0;
      if (lvl != last_level) begin
        dwell = 0;
        last_level = lvl;
      end
      if (!lvl) begin
        if (cls != CodeIdle) begin
          bump_dwell();
          if (dwell >= st + 1) cls = CodeIdle;
          else if (dwell >= st) cls = CodeRelease;
        end else begin
          dwell = 0;
        end
      end else begin
        if (cls != CodeLong) begin
          bump_dwell();
          if (dwell >= lt) cls = CodeLong;
          else if (dwell >= st + 1) cls = CodeShort;
          else if (dwell >= st) cls = CodePress;
        end else begin
          dwell = 0;
        end
      end
      // Derived outputs follow the new class
      if (cls == CodeShort) begin
        hold_flag = 1'b1;
        if (tog_armed) begin
          tog_flag  = ~tog_flag;
          tog_armed = 1'b0;
        end
        if (shot_armed) begin
          res.shot_pulse = 1'b1;
          shot_armed     = 1'b0;
        end
      end else if (cls == CodeRelease) begin
        hold_flag = 1'b0;
        tog_armed = 1'b1;
      end else if (cls == CodePress) begin
        shot_armed = 1'b1;
      end
      res.key_class    = cls;
      res.hold_level   = hold_flag;
      res.toggle_level = tog_flag;
      due_q.push_back(res);
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      fail_count++;
    endtask

    // Compare one accepted result with the oldest one owed
    task match_result(kpc_result_t got);
      kpc_result_t want;
      if (due_q.size() == 0) begin
        report($sformatf("result with nothing owed, class %0d", got.key_class));
      end else begin
        want = due_q.pop_front();
        if (got.key_class !== want.key_class)
          report($sformatf("key_class expected %0d got %0d", want.key_class,
                           got.key_class));
        if (got.hold_level !== want.hold_level)
          report($sformatf("hold_level expected %0d got %0d", want.hold_level,
                           got.hold_level));
        if (got.toggle_level !== want.toggle_level)
          report($sformatf("toggle_level expected %0d got %0d", want.toggle_level,
                           got.toggle_level));
        if (got.shot_pulse !== want.shot_pulse)
          report($sformatf("shot_pulse expected %0d got %0d", want.shot_pulse,
                           got.shot_pulse));
      end
    endtask

    function int pending();
      return due_q.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [AddrWidth-1:0]  paddr;
  logic [DataWidth-1:0]  pwdata;
  logic [DataWidth-1:0]  prdata;
  logic                  pready;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic                  key_level_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [ClassWidth-1:0] key_class_o;
  logic                  hold_level_o;
  logic                  toggle_level_o;
  logic                  shot_pulse_o;

  press_tracker trk;
  int           send_idle_pct;
  int           recv_stall_pct;
  bit           pressure_on;
  logic         cur_level;
  int           cur_short;
  int           cur_long;
  int           stall_cycles;

  key_press_classifier u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .key_level_i    (key_level_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .key_class_o    (key_class_o),
    .hold_level_o   (hold_level_o),
    .toggle_level_o (toggle_level_o),
    .shot_pulse_o   (shot_pulse_o)
  );

  always #2 clk_i = ~clk_i;

  // Stall the result channel at random
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Note accepted requests and check accepted results
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) trk.take_sample(key_level_i);
      if (out_valid_o && out_ready_i)
        trk.match_result('{key_class_o, hold_level_o, toggle_level_o, shot_pulse_o});
    end
  end

  // Drop the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || psel || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == StallLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offer one key sample, with random gaps ahead of it, and hold until taken
  task automatic send_key(input logic lvl);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    key_level_i <= lvl;
    cur_level   = lvl;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic run_key(input logic lvl, input int n_req);
    repeat (n_req) send_key(lvl);
  endtask

  // Hold requests off until every owed result has come, then let the pipe settle
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (trk.pending() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(input kpc_reg_e idx, input logic [CfgWidth-1:0] value);
    logic [DataWidth-1:0] word;
    word = {16'($urandom), value};
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    trk.set_threshold(idx, word);
  endtask

  task automatic set_thresholds(input int st, input int lt);
    wait_drain();
    apb_write(REG_SHORT_TIME, st[CfgWidth-1:0]);
    apb_write(REG_LONG_TIME, lt[CfgWidth-1:0]);
    cur_short = st;
    cur_long  = lt;
  endtask

  // Mostly alternating presses and releases around the thresholds, some noise
  task automatic random_runs(input int n_req);
    int   sent;
    int   roll;
    int   cap;
    int   len;
    logic lvl;
    sent = 0;
    while (sent < n_req) begin
      roll = $urandom_range(9);
      cap  = ((cur_long > cur_short) ? cur_long : cur_short) + 3;
      if (cap > 64) cap = 64;
      if (roll < 2) begin
        lvl = 1'($urandom_range(1));
        len = 1;
      end else begin
        lvl = ~cur_level;
        len = $urandom_range(cap, 1);
      end
      run_key(lvl, len);
      sent += len;
      if (pressure_on && $urandom_range(3) == 0) wait_drain();
    end
  endtask

  initial begin
    trk            = new();
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid_i     = 1'b0;
    key_level_i    = 1'b0;
    out_ready_i    = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    pressure_on    = 1'b0;
    cur_level      = 1'b0;
    cur_short      = ShortTimeRst;
    cur_long       = LongTimeRst;
    stall_cycles   = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset thresholds: press, short press, release, idle
    run_key(1'b1, 7);
    run_key(1'b0, 7);
    // Zero short time: press skipped, release goes straight to idle
    set_thresholds(0, 3);
    run_key(1'b1, 4);
    run_key(1'b0, 2);
    // Long time below short time: held-long wins
    set_thresholds(3, 2);
    run_key(1'b1, 3);
    run_key(1'b0, 4);
    // Release before short press is reached
    set_thresholds(3, 10);
    run_key(1'b1, 3);
    run_key(1'b0, 5);
    // Both thresholds at zero
    set_thresholds(0, 0);
    run_key(1'b1, 2);
    run_key(1'b0, 2);
    // Maximum thresholds: compares run at full precision, nothing is reached
    set_thresholds(16'hFFFF, 16'hFFFF);
    run_key(1'b1, 6);
    run_key(1'b0, 6);
    set_thresholds(2, 5);
    run_key(1'b0, 2);

    // Random phase without idling
    set_thresholds(2, 12);
    random_runs(100);
    // Sender idles
    send_idle_pct = 70;
    set_thresholds($urandom_range(6), $urandom_range(25));
    random_runs(100);
    // Receiver stalls
    send_idle_pct  = 0;
    recv_stall_pct = 70;
    set_thresholds(4, 20);
    random_runs(100);
    // Both sides idle, with pauses until drained
    send_idle_pct  = 22;
    recv_stall_pct = 22;
    pressure_on    = 1'b1;
    set_thresholds($urandom_range(1, 5), $urandom_range(4, 30));
    random_runs(100);

    pressure_on = 1'b0;
    wait_drain();
    repeat (6) @(posedge clk_i);
    if (trk.fail_count == 0 && trk.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* key_press_classifier.f */
rtl/kpc_pkg.sv
rtl/kpc_cfg_regs.sv
rtl/kpc_step.sv
rtl/key_press_classifier.sv
rtl/kpc_checker.sv
dv/key_press_classifier_tb.sv
